@@ design/pixel_binning_saturating_macros.svh @@
// ----------------------------------------------------------------------------
// Pixel binning assertion macros
// Concurrent assertion forms used by the pixel binning design file.
// ----------------------------------------------------------------------------
`ifndef PIXEL_BINNING_SATURATING_MACROS_SVH
`define PIXEL_BINNING_SATURATING_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside of reset.
`define PBS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every clock edge outside of reset.
`define PBS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/pbs_pkg.sv @@
// ----------------------------------------------------------------------------
// Pixel binning package
// Item types, register map codes and the saturating add shared by the design.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pbs_pkg;

    localparam int PIX_W     = 16;
    localparam int COL_OUT_W = 12;
    localparam int LW_W      = 13;
    localparam int LOG_W     = 2;
    localparam int BAND_W    = 2;
    localparam int APB_AW    = 4;
    localparam int APB_DW    = 32;

    // Register indexes, taken from paddr[3:2].
    localparam logic [1:0] REG_BIN_X_LOG  = 2'd0;
    localparam logic [1:0] REG_BIN_Y_LOG  = 2'd1;
    localparam logic [1:0] REG_LINE_WIDTH = 2'd2;

    localparam logic [LOG_W-1:0] BIN_X_LOG_RST  = 2'd1;
    localparam logic [LOG_W-1:0] BIN_Y_LOG_RST  = 2'd1;
    localparam logic [LW_W-1:0]  LINE_WIDTH_RST = 13'd4096;

    localparam logic [PIX_W-1:0] PIX_MAX = 16'hFFFF;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             frame_start;
    } t_in_item;

    typedef struct packed {
        logic [PIX_W-1:0]     binned_pixel;
        logic [COL_OUT_W-1:0] out_column;
        logic                 end_of_row;
    } t_out_item;

    // Unsigned add that clips at full scale.
    function automatic logic [PIX_W-1:0] sat_add(input logic [PIX_W-1:0] a,
                                                 input logic [PIX_W-1:0] b);
        logic [PIX_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[PIX_W] ? PIX_MAX : sum[PIX_W-1:0];
    endfunction

endpackage

@@ design/pbs_ram.sv @@
// ----------------------------------------------------------------------------
// Pixel binning RAM
// Simple dual-port synchronous RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pbs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/pixel_binning_saturating.sv @@
// ----------------------------------------------------------------------------
// Pixel binning, saturating
// Sums each bin_x by bin_y block of a 16-bit raster stream into one result.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake              Payload
//  input     in         i_valid / o_stall      i_in  (pixel, frame_start)
//  output    out        o_valid / i_stall      o_out (binned_pixel, out_column, end_of_row)
//  config    in         psel/penable/pwrite    paddr, pwdata, prdata, pready
//
//  One item is accepted per clock while the output side keeps up.
//  A result passes through the block stage, which waits for the line
//  accumulator read, and then through the output register.
//  The line accumulator is a single RAM, read once per block but on a band's
//  first row, written back but on its last; back-to-back same-entry access is forwarded.
//  Reset is synchronous; the RAM needs no clearing pass after reset.
//  A stall on the output holds the result; input is stalled only when a
//  finished block must still reach a full output register.
//
`timescale 1ns / 1ps
`include "pixel_binning_saturating_macros.svh"

module pixel_binning_saturating
    import pbs_pkg::*;
#(
    parameter int MAX_WIDTH = 4096
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // pixel stream in
    input  logic              i_valid,
    output logic              o_stall,
    input  t_in_item          i_in,
    // binned stream out
    output logic              o_valid,
    input  logic              i_stall,
    output t_out_item         o_out,
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    // Column counter width and the width that can hold the row width itself.
    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int CMPW = (WW > LW_W) ? WW : LW_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [LOG_W-1:0] r_bin_x_log;
    logic [LOG_W-1:0] r_bin_y_log;
    logic [LW_W-1:0]  r_line_width;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin_x_log  <= BIN_X_LOG_RST;
            r_bin_y_log  <= BIN_Y_LOG_RST;
            r_line_width <= LINE_WIDTH_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_BIN_X_LOG:  r_bin_x_log  <= pwdata[LOG_W-1:0];
                REG_BIN_Y_LOG:  r_bin_y_log  <= pwdata[LOG_W-1:0];
                REG_LINE_WIDTH: r_line_width <= pwdata[LW_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (paddr[3:2])
            REG_BIN_X_LOG:  prdata = {{(APB_DW-LOG_W){1'b0}}, r_bin_x_log};
            REG_BIN_Y_LOG:  prdata = {{(APB_DW-LOG_W){1'b0}}, r_bin_y_log};
            REG_LINE_WIDTH: prdata = {{(APB_DW-LW_W){1'b0}}, r_line_width};
            default:        prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Effective settings. A log of three acts as two; the row width is
    // clamped into one to MAX_WIDTH.
    // ------------------------------------------------------------------
    logic [LOG_W-1:0] xl;
    logic [LOG_W-1:0] yl;
    logic [1:0]       xmask;
    logic [1:0]       by_m1;
    logic [CMPW-1:0]  lw_ext;
    logic [CMPW-1:0]  w_cmp;
    logic [WW-1:0]    w_eff;
    logic [WW-1:0]    w_floor;
    logic [WW-1:0]    nblocks;

    always_comb begin
        xl = (r_bin_x_log > 2'd2) ? 2'd2 : r_bin_x_log;
        yl = (r_bin_y_log > 2'd2) ? 2'd2 : r_bin_y_log;
        case (xl)
            2'd0:    xmask = 2'd0;
            2'd1:    xmask = 2'd1;
            default: xmask = 2'd3;
        endcase
        case (yl)
            2'd0:    by_m1 = 2'd0;
            2'd1:    by_m1 = 2'd1;
            default: by_m1 = 2'd3;
        endcase
        lw_ext = CMPW'(r_line_width);
        if (lw_ext == '0) begin
            w_cmp = CMPW'(1);
        end else if (lw_ext > CMPW'(MAX_WIDTH)) begin
            w_cmp = CMPW'(MAX_WIDTH);
        end else begin
            w_cmp = lw_ext;
        end
        w_eff   = w_cmp[WW-1:0];
        // Columns at or beyond w_floor belong to no whole block.
        w_floor = w_eff & ~{{(WW-2){1'b0}}, xmask};
        nblocks = w_eff >> xl;
    end

    // ------------------------------------------------------------------
    // Position tracking and the horizontal partial sum
    // ------------------------------------------------------------------
    logic [CW-1:0]     r_col;
    logic [BAND_W-1:0] r_band;
    logic [PIX_W-1:0]  r_hsum;

    logic [CW-1:0]     col;
    logic [BAND_W-1:0] band;
    logic [PIX_W-1:0]  hsum;
    logic [1:0]        posx;
    logic              in_range;
    logic              blk_end;
    logic [PIX_W-1:0]  hs_new;
    logic [CW-1:0]     ocol;
    logic              last_blk;
    logic              band_last;
    logic [WW-1:0]     col_inc;
    logic              row_end;
    logic [CW-1:0]     n_col;
    logic [BAND_W-1:0] n_band;
    logic [PIX_W-1:0]  n_hsum;
    logic              in_acc;

    always_comb begin
        // A frame start clears the position and the running sum first.
        col       = i_in.frame_start ? '0 : r_col;
        band      = i_in.frame_start ? '0 : r_band;
        hsum      = i_in.frame_start ? '0 : r_hsum;
        posx      = col[1:0] & xmask;
        in_range  = WW'(col) < w_floor;
        blk_end   = in_range && (posx == xmask);
        hs_new    = (posx == 2'd0) ? i_in.pixel : sat_add(hsum, i_in.pixel);
        ocol      = col >> xl;
        last_blk  = (WW'(ocol) == (nblocks - WW'(1)));
        band_last = (band >= by_m1);
        col_inc   = WW'(col) + WW'(1);
        row_end   = (col_inc >= w_eff);
        n_col     = row_end ? '0 : col_inc[CW-1:0];
        if (row_end) begin
            n_band = band_last ? '0 : band + BAND_W'(1);
        end else begin
            n_band = band;
        end
        n_hsum = in_range ? hs_new : hsum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_band <= '0;
            r_hsum <= '0;
        end else if (in_acc) begin
            r_col  <= n_col;
            r_band <= n_band;
            r_hsum <= n_hsum;
        end
    end

    // ------------------------------------------------------------------
    // Block stage: holds the block while the line accumulator read completes,
    // then either emits the block or writes the vertical partial sum back.
    // ------------------------------------------------------------------
    logic              r_s1_valid;
    logic              r_s1_emit;
    logic              r_s1_rd;
    logic              r_s1_last;
    logic [CW-1:0]     r_s1_ocol;
    logic [PIX_W-1:0]  r_s1_hs;
    logic              r_s1_fwd;
    logic [PIX_W-1:0]  r_s1_fwd_data;

    logic              out_free;
    logic              s1_move;
    logic              ram_re;
    logic              ram_we;
    logic [PIX_W-1:0]  ram_rdata;
    logic [PIX_W-1:0]  acc_base;
    logic [PIX_W-1:0]  s1_sum;
    logic              fwd_hit;

    assign out_free = !o_valid || !i_stall;
    assign s1_move  = r_s1_valid && (!r_s1_emit || out_free);
    assign o_stall  = r_s1_valid && !s1_move;
    assign in_acc   = i_valid && !o_stall;

    // The first row of a band starts the vertical sum and reads nothing.
    assign ram_re  = in_acc && blk_end && (band != '0);
    assign ram_we  = s1_move && !r_s1_emit;
    // The entry being written this cycle is the one about to be read:
    // the RAM returns old data, so the new value is kept aside.
    assign fwd_hit = ram_re && ram_we && (r_s1_ocol == ocol);

    assign acc_base = r_s1_fwd ? r_s1_fwd_data : ram_rdata;
    assign s1_sum   = r_s1_rd ? sat_add(acc_base, r_s1_hs) : r_s1_hs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= blk_end;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && blk_end) begin
            r_s1_emit     <= band_last;
            r_s1_rd       <= (band != '0);
            r_s1_last     <= last_blk;
            r_s1_ocol     <= ocol;
            r_s1_hs       <= hs_new;
            r_s1_fwd      <= fwd_hit;
            r_s1_fwd_data <= s1_sum;
        end
    end

    pbs_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_acc (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_s1_ocol),
        .i_wdata (s1_sum),
        .i_re    (ram_re),
        .i_raddr (ocol),
        .o_rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic                    r_out_valid;
    t_out_item               r_out;
    logic [CW+COL_OUT_W-1:0] ocol_wide;

    assign ocol_wide = {{COL_OUT_W{1'b0}}, r_s1_ocol};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= s1_move && r_s1_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && s1_move && r_s1_emit) begin
            r_out.binned_pixel <= s1_sum;
            r_out.out_column   <= ocol_wide[COL_OUT_W-1:0];
            r_out.end_of_row   <= r_s1_last;
        end
    end

    assign o_valid = r_out_valid;
    assign o_out   = r_out;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `PBS_ASSERT_NOW(a_fwd_needs_read, r_s1_valid && r_s1_fwd, r_s1_rd, "forward without read")
    `PBS_ASSERT_NOW(a_acc_frees_s1, in_acc && r_s1_valid, s1_move, "block stage overwritten")
    `PBS_ASSERT_NEXT(a_out_from_s1, !o_valid && !(s1_move && r_s1_emit), !o_valid, "spurious result")
    `PBS_ASSERT_NEXT(a_wr_no_out, ram_we && o_valid && i_stall, o_valid && $stable(o_out), "write disturbed output")

endmodule
